>>> sv/ffsa_pkg.sv
// Shared types and codes for the first-fit slot allocator.
// No dependencies; used by first_fit_slot_allocator.
package ffsa_pkg;

    // Request codes carried on the op field
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Width of the run_length field; FREE_W is the saturation width of free_slots
    localparam int LEN_W  = 5;
    localparam int HND_W  = 4;
    localparam int OCC_W  = 16;
    localparam int FREE_W = 5;
    localparam logic [FREE_W-1:0] FREE_MAX = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } ffsa_state_t;

endpackage

>>> sv/first_fit_slot_allocator.sv
// First-fit contiguous slot allocator: owner table, shared scan sequencer, output register.
// Depends on ffsa_pkg.
// Allocate scans the slots one index at a time for a free run of run_length, then marks
// that run; free walks every slot; an allocate with a bad length goes straight to done.
// One item at a time: in_stall is high from acceptance until the result is loaded.
// Reset (rst_n low, asynchronous) marks every slot free and clears the output valid flag.
module first_fit_slot_allocator #(
    parameter int SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [ffsa_pkg::LEN_W-1:0]    run_length,
    input  logic [ffsa_pkg::HND_W-1:0]    handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [ffsa_pkg::HND_W-1:0]    start_slot,
    output logic [ffsa_pkg::OCC_W-1:0]    occupancy,
    output logic [ffsa_pkg::FREE_W-1:0]   free_slots
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int LW    = (CNT_W > ffsa_pkg::LEN_W) ? CNT_W : ffsa_pkg::LEN_W;
    localparam int HW    = (IDX_W > ffsa_pkg::HND_W) ? IDX_W : ffsa_pkg::HND_W;
    localparam int FW    = (CNT_W > ffsa_pkg::FREE_W) ? CNT_W : ffsa_pkg::FREE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    ffsa_pkg::ffsa_state_t state_reg, state_next;

    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [IDX_W-1:0]    owner_reg [SLOTS];
    logic                owner_we;
    logic [IDX_W-1:0]    owner_wdata;

    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [CNT_W-1:0]    run_start_reg, run_start_next;
    logic [CNT_W-1:0]    free_cnt_reg, free_cnt_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [ffsa_pkg::HND_W-1:0] hnd_reg, hnd_next;
    logic                res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]    res_start_reg, res_start_next;

    logic                out_valid_reg, out_valid_next;
    logic                ok_reg, ok_next;
    logic [ffsa_pkg::HND_W-1:0]  start_reg, start_next;
    logic [ffsa_pkg::OCC_W-1:0]  occ_reg, occ_next;
    logic [ffsa_pkg::FREE_W-1:0] free_reg, free_next;

    logic [ffsa_pkg::OCC_W-1:0]  occ_now;
    logic [FW-1:0]       free_ext;
    logic [HW-1:0]       start_ext;
    logic [LW-1:0]       run_inc;
    logic                in_take;
    logic                len_ok;
    logic                slot_used;
    logic [IDX_W-1:0]    cur_owner;

    generate
        for (genvar b = 0; b < ffsa_pkg::OCC_W; b++) begin : g_occ
            if (b < SLOTS) begin : g_on
                assign occ_now[b] = valid_reg[b];
            end
            else begin : g_off
                assign occ_now[b] = 1'b0;
            end
        end
    endgenerate

    assign free_ext  = FW'(free_cnt_reg);
    assign start_ext = HW'(res_start_reg);
    assign in_take   = in_valid && (state_reg == ffsa_pkg::ST_IDLE);
    assign len_ok    = (run_length != '0) && (LW'(run_length) <= LW'(SLOTS));
    assign slot_used = valid_reg[idx_reg];
    assign cur_owner = owner_reg[idx_reg];
    assign run_inc   = LW'(run_reg) + LW'(1);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        run_start_next = run_start_reg;
        free_cnt_next  = free_cnt_reg;
        len_next       = len_reg;
        hnd_next       = hnd_reg;
        res_ok_next    = res_ok_reg;
        res_start_next = res_start_reg;
        owner_we       = 1'b0;
        owner_wdata    = res_start_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        start_next     = start_reg;
        occ_next       = occ_reg;
        free_next      = free_reg;

        unique case (state_reg)
            ffsa_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    idx_next       = '0;
                    run_next       = '0;
                    run_start_next = '0;
                    len_next       = LW'(run_length);
                    hnd_next       = handle;
                    res_ok_next    = 1'b0;
                    res_start_next = '0;
                    if (op == ffsa_pkg::OP_FREE)
                    begin
                        res_ok_next = 1'b1;
                        state_next  = ffsa_pkg::ST_FREE;
                    end
                    else if (len_ok)
                    begin
                        state_next = ffsa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = ffsa_pkg::ST_DONE;
                    end
                end
            end

            ffsa_pkg::ST_SCAN:
            begin
                if (slot_used)
                begin
                    run_next       = '0;
                    run_start_next = CNT_W'(idx_reg) + CNT_W'(1);
                end
                else
                begin
                    run_next = CNT_W'(run_inc);
                end
                if (!slot_used && (run_inc == len_reg))
                begin
                    // run found: rewind to its start and mark it
                    res_start_next = run_start_reg[IDX_W-1:0];
                    idx_next       = run_start_reg[IDX_W-1:0];
                    run_next       = '0;
                    state_next     = ffsa_pkg::ST_MARK;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ffsa_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ffsa_pkg::ST_MARK:
            begin
                owner_we            = 1'b1;
                valid_next[idx_reg] = 1'b1;
                free_cnt_next       = free_cnt_reg - CNT_W'(1);
                run_next            = CNT_W'(run_inc);
                if (run_inc == len_reg)
                begin
                    res_ok_next = 1'b1;
                    state_next  = ffsa_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ffsa_pkg::ST_FREE:
            begin
                if (slot_used && (HW'(cur_owner) == HW'(hnd_reg)))
                begin
                    valid_next[idx_reg] = 1'b0;
                    free_cnt_next       = free_cnt_reg + CNT_W'(1);
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ffsa_pkg::ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ffsa_pkg::ST_DONE:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    start_next     = start_ext[ffsa_pkg::HND_W-1:0];
                    occ_next       = occ_now;
                    free_next      = (free_ext > FW'(ffsa_pkg::FREE_MAX)) ?
                                     ffsa_pkg::FREE_MAX : free_ext[ffsa_pkg::FREE_W-1:0];
                    state_next     = ffsa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ffsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffsa_pkg::ST_IDLE;
            valid_reg     <= '0;
            free_cnt_reg  <= CNT_W'(SLOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            free_cnt_reg  <= free_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        run_reg       <= run_next;
        run_start_reg <= run_start_next;
        len_reg       <= len_next;
        hnd_reg       <= hnd_next;
        res_ok_reg    <= res_ok_next;
        res_start_reg <= res_start_next;
        ok_reg        <= ok_next;
        start_reg     <= start_next;
        occ_reg       <= occ_next;
        free_reg      <= free_next;
        if (owner_we)
        begin
            owner_reg[idx_reg] <= owner_wdata;
        end
    end

    assign in_stall   = (state_reg != ffsa_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign start_slot = start_reg;
    assign occupancy  = occ_reg;
    assign free_slots = free_reg;

    // free counter tracks the valid bits whenever the sequencer rests
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffsa_pkg::ST_IDLE) |->
        (free_cnt_reg == CNT_W'(SLOTS) - CNT_W'($countones(valid_reg))))
        else $error("free slot counter out of step with valid bits");

    // marking only ever claims a slot that the scan saw free
    a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffsa_pkg::ST_MARK) |-> !valid_reg[idx_reg])
        else $error("mark phase hit an occupied slot");

    // a failed allocate reports start zero
    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (start_reg == '0))
        else $error("failed result carries a nonzero start");

    // a result is loaded exactly when the sequencer leaves the done state
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ffsa_pkg::ST_DONE) && (state_next == ffsa_pkg::ST_IDLE)) |=>
        out_valid_reg)
        else $error("done state left without a result");

endmodule

>>> sim/slot_pool_check_pkg.sv
// Scoreboard for the first-fit slot allocator: a predictor of the slot pool and a queue
// of expected results. Depends on ffsa_pkg.
`timescale 1ns / 1ps

package slot_pool_check_pkg;
    import ffsa_pkg::*;

    localparam int POOL_SLOTS = 16;

    typedef struct packed {
        logic              ok;
        logic [HND_W-1:0]  start;
        logic [OCC_W-1:0]  occ;
        logic [FREE_W-1:0] nfree;
    } slot_result_t;

    class slot_pool_scoreboard;
        logic              slot_used  [POOL_SLOTS];
        int unsigned       slot_owner [POOL_SLOTS];
        slot_result_t      expected_results [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                slot_used[i]  = 1'b0;
                slot_owner[i] = 0;
            end
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // start of some live run, or -1 when the pool is empty
        function int live_start();
            int picks [$];
            for (int i = 0; i < POOL_SLOTS; i++)
                if (slot_used[i] && slot_owner[i] == i && i < (1 << HND_W))
                    picks.push_back(i);
            if (picks.size() == 0)
                return -1;
            return picks[$urandom_range(picks.size() - 1)];
        endfunction

        // apply one accepted item to the pool and queue the result it must give
        function void note_request(logic opc, logic [LEN_W-1:0] len, logic [HND_W-1:0] hnd);
            slot_result_t r;
            int           run;
            int           first;
            bit           hit;
            int unsigned  nfree;
            r     = '0;
            run   = 0;
            first = 0;
            hit   = 0;
            nfree = 0;
            if (opc == OP_ALLOC)
            begin
                if (len >= 1 && len <= POOL_SLOTS)
                begin
                    for (int i = 0; i < POOL_SLOTS && !hit; i++)
                    begin
                        run = slot_used[i] ? 0 : run + 1;
                        if (run == len)
                        begin
                            first = i + 1 - len;
                            hit   = 1;
                        end
                    end
                    if (hit)
                    begin
                        for (int i = first; i < first + len; i++)
                        begin
                            slot_used[i]  = 1'b1;
                            slot_owner[i] = first;
                        end
                        r.ok    = 1'b1;
                        r.start = first[HND_W-1:0];
                    end
                end
            end
            else
            begin
                for (int i = 0; i < POOL_SLOTS; i++)
                    if (slot_used[i] && slot_owner[i] == hnd)
                    begin
                        slot_used[i]  = 1'b0;
                        slot_owner[i] = 0;
                    end
                r.ok = 1'b1;
            end
            for (int i = 0; i < POOL_SLOTS; i++)
            begin
                if (!slot_used[i])
                    nfree++;
                if (i < OCC_W && slot_used[i])
                    r.occ[i] = 1'b1;
            end
            r.nfree = (nfree > FREE_MAX) ? FREE_MAX : nfree[FREE_W-1:0];
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic got_ok, logic [HND_W-1:0] got_start,
                          logic [OCC_W-1:0] got_occ, logic [FREE_W-1:0] got_free);
            slot_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with nothing outstanding");
                return;
            end
            want = expected_results.pop_front();
            if (got_ok !== want.ok)
                report_mismatch($sformatf("ok got %b want %b", got_ok, want.ok));
            if (got_start !== want.start)
                report_mismatch($sformatf("start_slot got %0d want %0d", got_start, want.start));
            if (got_occ !== want.occ)
                report_mismatch($sformatf("occupancy got %h want %h", got_occ, want.occ));
            if (got_free !== want.nfree)
                report_mismatch($sformatf("free_slots got %0d want %0d", got_free, want.nfree));
        endtask
    endclass

endpackage

>>> sim/tb_first_fit_slot_allocator.sv
// Testbench top for first_fit_slot_allocator: drives allocate/free items, checks every
// result against slot_pool_scoreboard. Depends on ffsa_pkg and slot_pool_check_pkg.
`timescale 1ns / 1ps

module tb_first_fit_slot_allocator;
    import ffsa_pkg::*;
    import slot_pool_check_pkg::*;

    localparam int RANDOM_ITEMS = 1300;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              op;
    logic [LEN_W-1:0]  run_length;
    logic [HND_W-1:0]  handle;
    logic              out_valid;
    logic              out_stall;
    logic              ok;
    logic [HND_W-1:0]  start_slot;
    logic [OCC_W-1:0]  occupancy;
    logic [FREE_W-1:0] free_slots;

    slot_pool_scoreboard sb;
    bit                  quiet;     // no idling on either side
    bit                  hold_req;  // receiver holds off for a long stretch

    first_fit_slot_allocator #(
        .SLOTS(POOL_SLOTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .run_length (run_length),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .start_slot (start_slot),
        .occupancy  (occupancy),
        .free_slots (free_slots)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // call right after a rising edge; returns at the edge where the item is taken
    task automatic send_item(input logic opc, input logic [LEN_W-1:0] len,
                             input logic [HND_W-1:0] hnd);
        while (!quiet && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= opc;
        run_length <= len;
        handle     <= hnd;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(opc, len, hnd);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return LEN_W'($urandom_range(4, 1));
        else if (roll < 90)
            return LEN_W'($urandom_range(10, 5));
        return LEN_W'($urandom_range(POOL_SLOTS, 11));
    endfunction

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            out_stall <= !quiet && ($urandom_range(99) < 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(ok, start_slot, occupancy, free_slots);
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int live;
        sb         = new();
        quiet      = 1'b0;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        op         <= OP_ALLOC;
        run_length <= '0;
        handle     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad lengths, full pool, no-fit, free of nothing, top slot, fragmentation
        send_item(OP_ALLOC, 5'd0,  4'd9);
        send_item(OP_ALLOC, 5'd17, 4'd0);
        send_item(OP_ALLOC, 5'd31, 4'd15);
        send_item(OP_FREE,  5'd31, 4'd0);
        send_item(OP_ALLOC, 5'd16, 4'd0);
        send_item(OP_ALLOC, 5'd1,  4'd0);
        send_item(OP_FREE,  5'd0,  4'd15);
        send_item(OP_FREE,  5'd0,  4'd0);
        send_item(OP_ALLOC, 5'd15, 4'd0);
        send_item(OP_ALLOC, 5'd1,  4'd0);
        send_item(OP_ALLOC, 5'd2,  4'd0);
        send_item(OP_FREE,  5'd1,  4'd15);
        send_item(OP_FREE,  5'd1,  4'd0);
        send_item(OP_ALLOC, 5'd4,  4'd0);
        send_item(OP_ALLOC, 5'd4,  4'd0);
        send_item(OP_ALLOC, 5'd4,  4'd0);
        send_item(OP_ALLOC, 5'd4,  4'd0);
        send_item(OP_FREE,  5'd0,  4'd4);
        send_item(OP_ALLOC, 5'd5,  4'd0);
        send_item(OP_ALLOC, 5'd3,  4'd0);
        send_item(OP_ALLOC, 5'd1,  4'd0);
        send_item(OP_FREE,  5'd0,  4'd8);
        send_item(OP_FREE,  5'd0,  4'd12);
        send_item(OP_ALLOC, 5'd8,  4'd0);
        send_item(OP_FREE,  5'd0,  4'd0);

        // sender pauses until the pool is quiet
        in_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
                hold_req = 1'b1;
            quiet = (n >= 400 && n < 600);
            if (n == 800)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(99) < 75)
            begin
                // well-formed: allocate a plausible run or free a live one
                live = sb.live_start();
                if (live >= 0 && $urandom_range(99) < 45)
                    send_item(OP_FREE, LEN_W'($urandom()), live[HND_W-1:0]);
                else
                    send_item(OP_ALLOC, pick_length(), HND_W'($urandom()));
            end
            else if ($urandom_range(1) == 0)
                send_item(OP_ALLOC, LEN_W'($urandom()), HND_W'($urandom()));
            else
                send_item(OP_FREE, LEN_W'($urandom()), HND_W'($urandom()));
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
